@@ rtl/fme_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fme_pkg
// Shared types and constants of the multichannel fade engine.
// ----------------------------------------------------------------------------
package fme_pkg;

  localparam int unsigned CH_IDX_W = 2;
  localparam int unsigned MAX_CH   = 4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  channel;
    logic [7:0]  speed;
    logic [1:0]  direction;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] level_ch0;
    logic [15:0] level_ch1;
    logic [15:0] level_ch2;
    logic [15:0] level_ch3;
    logic [3:0]  report_mask;
  } out_item_t;

  // Per-channel view handed to the shared step unit.
  typedef struct packed {
    logic [15:0]       level;
    logic [15:0]       target;
    logic signed [8:0] rate;
  } ch_view_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_A,
    ST_TICK_B,
    ST_CMD_A,
    ST_CMD_B,
    ST_CLAMP
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIP,
    PH_RISE,
    PH_BACK
  } phase_t;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_DEMO  = 3'd2;
  localparam logic [2:0] CMD_START = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;
  localparam logic [2:0] CMD_ABS   = 3'd5;
  localparam logic [2:0] CMD_REL   = 3'd6;

  localparam logic [1:0] DIR_UP   = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;

  localparam logic [1:0] REG_MIN_LEVEL   = 2'd0;
  localparam logic [1:0] REG_MAX_LEVEL   = 2'd1;
  localparam logic [1:0] REG_STEP_UNIT   = 2'd2;
  localparam logic [1:0] REG_CLAMP_LEVEL = 2'd3;

  localparam logic [15:0] MIN_LEVEL_RST   = 16'd0;
  localparam logic [15:0] MAX_LEVEL_RST   = 16'd10000;
  localparam logic [7:0]  STEP_UNIT_RST   = 8'd39;
  localparam logic [15:0] CLAMP_LEVEL_RST = 16'd10000;

  localparam logic [7:0] SPEED_FAST_BIT = 8'h80;
  localparam logic [7:0] SPEED_LOW_MASK = 8'h7f;

endpackage : fme_pkg
`default_nettype wire

@@ rtl/multichannel_fade_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_fade_engine
// Dimmer fade engine: commands set levels, start fades or demos, and tick
// beats step every channel through one shared step unit.
// ----------------------------------------------------------------------------
// Sequence: a tick takes each channel through TICK_A and TICK_B in the
// shared multiply and add unit, then goes to CLAMP; set, stop and a demo
// with speed 0 go CMD_A, CLAMP; other fades and demos CMD_A, CMD_B, CLAMP;
// an ignored beat goes straight to CLAMP. One beat is worked on at a time
// and a waiting result holds the clamp state. Synchronous active-low reset
// resets control, config and channel registers, not item, tmp or out data.
// ----------------------------------------------------------------------------
module multichannel_fade_engine
  import fme_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers
  logic [15:0] min_level_r, max_level_r, clamp_level_r;
  logic [7:0]  step_unit_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r   <= MIN_LEVEL_RST;
      max_level_r   <= MAX_LEVEL_RST;
      step_unit_r   <= STEP_UNIT_RST;
      clamp_level_r <= CLAMP_LEVEL_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MIN_LEVEL:   min_level_r   <= pwdata[15:0];
        REG_MAX_LEVEL:   max_level_r   <= pwdata[15:0];
        REG_STEP_UNIT:   step_unit_r   <= pwdata[7:0];
        REG_CLAMP_LEVEL: clamp_level_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN_LEVEL:   prdata = {16'd0, min_level_r};
      REG_MAX_LEVEL:   prdata = {16'd0, max_level_r};
      REG_STEP_UNIT:   prdata = {24'd0, step_unit_r};
      REG_CLAMP_LEVEL: prdata = {16'd0, clamp_level_r};
      default:         prdata = 32'd0;
    endcase
  end

  // Sequencer and channel state
  state_t state_r, state_nxt;
  logic [CH_IDX_W-1:0] ch_r, ch_nxt;
  in_item_t item_r, item_nxt;
  logic [3:0] mask_r, mask_nxt;
  logic [15:0] tmp_a_r, tmp_a_nxt, tmp_b_r, tmp_b_nxt;
  logic do_step_r, do_step_nxt;
  out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [15:0]       level_r [CHANNELS];
  logic [15:0]       level_nxt [CHANNELS];
  logic [15:0]       target_r [CHANNELS];
  logic [15:0]       target_nxt [CHANNELS];
  logic signed [8:0] rate_r [CHANNELS];
  logic signed [8:0] rate_nxt [CHANNELS];
  logic [7:0]        divider_r [CHANNELS];
  logic [7:0]        divider_nxt [CHANNELS];
  logic [7:0]        tcount_r [CHANNELS];
  logic [7:0]        tcount_nxt [CHANNELS];
  phase_t            phase_r [CHANNELS];
  phase_t            phase_nxt [CHANNELS];
  logic [15:0]       dret_r [CHANNELS];
  logic [15:0]       dret_nxt [CHANNELS];
  logic [15:0]       dpeak_r [CHANNELS];
  logic [15:0]       dpeak_nxt [CHANNELS];
  logic [15:0]       clamped [CHANNELS];

  logic              in_fire;
  logic              slot_free;
  logic              ch_ok;
  logic              last_ch;
  logic [CH_IDX_W-1:0] sel;
  logic [15:0]       cur_level;
  logic [15:0]       cur_target;
  logic signed [8:0] cur_rate;

  // Tick phase A signals
  logic [15:0]       ta_target;
  logic signed [8:0] ta_rate;
  phase_t            ta_phase;
  logic [7:0]        ta_count;
  logic              ta_step;

  // Command helpers
  logic              fast;
  logic signed [8:0] set_rate_val;
  logic [7:0]        set_div_val;
  logic [16:0]       rel_up;
  logic [15:0]       rel_end;
  logic [15:0]       start_end;
  logic [15:0]       demo_tgt;
  logic [15:0]       demo_peak;
  logic              cover_min;
  logic              cover_max;

  // Step unit
  ch_view_t          su_view;
  logic [15:0]       su_level;
  logic              su_hit;
  logic              su_mul_en;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign ch_ok     = ({30'd0, in_data.channel} < 32'(CHANNELS));
  assign last_ch   = ({30'd0, ch_r} == 32'(CHANNELS - 1));
  assign sel       = ((state_r == ST_TICK_A) || (state_r == ST_TICK_B)) ? ch_r
                                                                       : item_r.channel;
  assign cur_level  = level_r[sel];
  assign cur_target = target_r[sel];
  assign cur_rate   = rate_r[sel];

  assign fast         = (item_r.speed & SPEED_FAST_BIT) != 8'd0;
  assign set_rate_val = fast ? $signed({2'b00, item_r.speed[6:0]}) + 9'sd1 : 9'sd1;
  assign set_div_val  = fast ? 8'd1 : 8'h80 - (item_r.speed & SPEED_LOW_MASK);

  assign rel_up = {1'b0, cur_level} + {1'b0, item_r.value};

  always_comb begin
    case (item_r.direction)
      DIR_UP:   rel_end = rel_up[16] ? max_level_r : rel_up[15:0];
      DIR_DOWN: rel_end = (item_r.value > cur_level) ? min_level_r
                                                     : cur_level - item_r.value;
      default:  rel_end = cur_level;
    endcase
    case (item_r.direction)
      DIR_UP:   start_end = max_level_r;
      DIR_DOWN: start_end = min_level_r;
      default:  start_end = 16'd0;
    endcase
  end

  // Demo targets: tmp_a holds the distance to min_level, tmp_b to max_level.
  // The level plus its distance to max_level is max_level, which shortens
  // the one-sided cases to a single add.
  assign cover_min = (tmp_a_r >= item_r.value);
  assign cover_max = (tmp_b_r >= item_r.value);

  always_comb begin
    demo_tgt  = cur_target;
    demo_peak = dpeak_r[sel];
    if (cover_min && cover_max) begin
      demo_tgt  = cur_level - item_r.value;
      demo_peak = cur_level + item_r.value;
    end else if (cover_min) begin
      demo_tgt  = max_level_r - {item_r.value[14:0], 1'b0};
      demo_peak = max_level_r;
    end else if (cover_max) begin
      demo_tgt  = min_level_r;
      demo_peak = min_level_r + {item_r.value[14:0], 1'b0};
    end
  end

  // Tick phase A: demo advance at the target, then the divider count.
  always_comb begin
    ta_target = cur_target;
    ta_rate   = cur_rate;
    ta_phase  = phase_r[sel];
    if (cur_level == cur_target) begin
      case (phase_r[sel])
        PH_DIP: begin
          ta_phase  = PH_RISE;
          ta_target = dpeak_r[sel];
          ta_rate   = -cur_rate;
        end
        PH_RISE: begin
          ta_phase  = PH_BACK;
          ta_target = dret_r[sel];
          ta_rate   = -cur_rate;
        end
        PH_BACK: ta_phase = PH_IDLE;
        default: ;
      endcase
    end
    ta_count = tcount_r[sel] + 8'd1;
    ta_step  = (ta_count == divider_r[sel]) && (cur_level != ta_target);
  end

  assign su_mul_en      = (state_r == ST_TICK_A);
  assign su_view.level  = cur_level;
  assign su_view.target = cur_target;
  assign su_view.rate   = cur_rate;

  fme_step_unit u_step (
    .clk        (clk),
    .mul_en     (su_mul_en),
    .mul_rate   (ta_rate),
    .step_unit  (step_unit_r),
    .view       (su_view),
    .next_level (su_level),
    .hit        (su_hit)
  );

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      clamped[i] = (level_r[i] > clamp_level_r) ? clamp_level_r : level_r[i];
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.cmd == CMD_TICK) begin
            state_nxt = ST_TICK_A;
          end else if (ch_ok && (in_data.cmd inside {[CMD_SET:CMD_REL]})) begin
            state_nxt = ST_CMD_A;
          end else begin
            state_nxt = ST_CLAMP;
          end
        end
      end
      ST_TICK_A: state_nxt = ST_TICK_B;
      ST_TICK_B: state_nxt = last_ch ? ST_CLAMP : ST_TICK_A;
      ST_CMD_A: begin
        case (item_r.cmd)
          CMD_DEMO: state_nxt = (item_r.speed != 8'd0) ? ST_CMD_B : ST_CLAMP;
          CMD_START, CMD_ABS, CMD_REL: state_nxt = ST_CMD_B;
          default: state_nxt = ST_CLAMP;
        endcase
      end
      ST_CMD_B: state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = slot_free ? ST_IDLE : ST_CLAMP;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output logic
  always_comb begin
    item_nxt      = item_r;
    ch_nxt        = ch_r;
    mask_nxt      = mask_r;
    tmp_a_nxt     = tmp_a_r;
    tmp_b_nxt     = tmp_b_r;
    do_step_nxt   = do_step_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    level_nxt     = level_r;
    target_nxt    = target_r;
    rate_nxt      = rate_r;
    divider_nxt   = divider_r;
    tcount_nxt    = tcount_r;
    phase_nxt     = phase_r;
    dret_nxt      = dret_r;
    dpeak_nxt     = dpeak_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          mask_nxt = 4'd0;
          ch_nxt   = '0;
        end
      end

      ST_TICK_A: begin
        target_nxt[sel] = ta_target;
        rate_nxt[sel]   = ta_rate;
        phase_nxt[sel]  = ta_phase;
        tcount_nxt[sel] = ta_step ? 8'd0 : ta_count;
        do_step_nxt     = ta_step;
      end

      ST_TICK_B: begin
        if (do_step_r) begin
          level_nxt[sel] = su_level;
          if (su_hit) begin
            mask_nxt[sel] = 1'b1;
          end
        end
        ch_nxt = ch_r + 1'b1;
      end

      ST_CMD_A: begin
        case (item_r.cmd)
          CMD_SET: level_nxt[sel] = item_r.value;
          CMD_STOP: begin
            phase_nxt[sel] = PH_IDLE;
            rate_nxt[sel]  = 9'sd0;
            mask_nxt[sel]  = 1'b1;
          end
          CMD_DEMO: begin
            tcount_nxt[sel] = 8'd0;
            rate_nxt[sel]   = 9'sd0;
            tmp_a_nxt       = cur_level - min_level_r;
            tmp_b_nxt       = max_level_r - cur_level;
          end
          CMD_START, CMD_ABS, CMD_REL: begin
            phase_nxt[sel]  = PH_IDLE;
            tcount_nxt[sel] = 8'd0;
            rate_nxt[sel]   = 9'sd0;
            case (item_r.cmd)
              CMD_START: tmp_a_nxt = start_end;
              CMD_REL:   tmp_a_nxt = rel_end;
              default:   tmp_a_nxt = item_r.value;
            endcase
          end
          default: ;
        endcase
      end

      ST_CMD_B: begin
        if (item_r.cmd == CMD_DEMO) begin
          dret_nxt[sel]    = cur_level;
          target_nxt[sel]  = demo_tgt;
          dpeak_nxt[sel]   = demo_peak;
          phase_nxt[sel]   = PH_DIP;
          divider_nxt[sel] = set_div_val;
          rate_nxt[sel]    = (demo_tgt <= cur_level) ? -set_rate_val : set_rate_val;
        end else if (item_r.speed == 8'd0) begin
          level_nxt[sel] = tmp_a_r;
          mask_nxt[sel]  = 1'b1;
        end else begin
          target_nxt[sel] = tmp_a_r;
          if (tmp_a_r != cur_level) begin
            divider_nxt[sel] = set_div_val;
            rate_nxt[sel]    = (tmp_a_r < cur_level) ? -set_rate_val : set_rate_val;
          end
        end
      end

      ST_CLAMP: begin
        level_nxt = clamped;
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.level_ch0   = clamped[0];
          out_nxt.level_ch1   = (CHANNELS > 1) ? clamped[1 % CHANNELS] : 16'd0;
          out_nxt.level_ch2   = (CHANNELS > 2) ? clamped[2 % CHANNELS] : 16'd0;
          out_nxt.level_ch3   = (CHANNELS > 3) ? clamped[3 % CHANNELS] : 16'd0;
          out_nxt.report_mask = mask_r;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      mask_r      <= 4'd0;
      do_step_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        level_r[i]   <= 16'd0;
        target_r[i]  <= 16'd0;
        rate_r[i]    <= 9'sd0;
        divider_r[i] <= 8'd0;
        tcount_r[i]  <= 8'd0;
        phase_r[i]   <= PH_IDLE;
        dret_r[i]    <= 16'd0;
        dpeak_r[i]   <= 16'd0;
      end
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      mask_r      <= mask_nxt;
      do_step_r   <= do_step_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
      target_r    <= target_nxt;
      rate_r      <= rate_nxt;
      divider_r   <= divider_nxt;
      tcount_r    <= tcount_nxt;
      phase_r     <= phase_nxt;
      dret_r      <= dret_nxt;
      dpeak_r     <= dpeak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    tmp_a_r <= tmp_a_nxt;
    tmp_b_r <= tmp_b_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule : multichannel_fade_engine
`default_nettype wire

@@ rtl/fme_step_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fme_step_unit
// Shared fade step unit: registered rate times step_unit, then add to the
// level with clamping at the target on overshoot or wrap.
// ----------------------------------------------------------------------------
module fme_step_unit
  import fme_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              mul_en,
  input  wire logic signed [8:0] mul_rate,
  input  wire logic [7:0]        step_unit,
  input  wire ch_view_t          view,
  output logic [15:0]            next_level,
  output logic                   hit
);

  logic signed [17:0] prod_r;
  logic [15:0]        sum;
  logic               rate_pos;
  logic               rate_neg;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_rate * $signed({1'b0, step_unit});
    end
  end

  // Only the low 16 bits of the step matter, the level wraps modulo 2^16.
  assign sum      = view.level + prod_r[15:0];
  assign rate_neg = view.rate[8];
  assign rate_pos = !view.rate[8] && (view.rate != 9'sd0);

  always_comb begin
    next_level = sum;
    if (rate_pos && ((sum < view.level) || (sum >= view.target))) begin
      next_level = view.target;
    end else if (rate_neg && ((sum > view.level) || (sum <= view.target))) begin
      next_level = view.target;
    end
  end

  assign hit = (next_level == view.target);

endmodule : fme_step_unit
`default_nettype wire
